// ===== hdl/icfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfb_pkg: shared definitions for the IDEA block cipher with CFB feedback
// Round count, subkey memory layout, codes and the arithmetic helpers.
// ----------------------------------------------------------------------------
package icfb_pkg;

	localparam int ROUND_COUNT  = 8;
	localparam int SUBKEY_COUNT = 6 * ROUND_COUNT + 4;
	localparam int KIDX_W       = $clog2(SUBKEY_COUNT);
	// One memory row holds the six subkeys of one round; the output
	// transform takes a row of its own. Encryption rows come first.
	localparam int ROW_COUNT    = 2 * (ROUND_COUNT + 1);
	localparam int ROW_AW       = $clog2(ROW_COUNT);
	localparam int ROW_W        = 96;
	localparam int RND_W        = $clog2(ROUND_COUNT + 1);
	localparam int KEY_W        = 128;

	// Operating modes
	localparam logic [1:0] MODE_ECB_ENC = 2'd0;
	localparam logic [1:0] MODE_ECB_DEC = 2'd1;
	localparam logic [1:0] MODE_CFB_ENC = 2'd2;
	localparam logic [1:0] MODE_CFB_DEC = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
	localparam logic [1:0] CFG_IV       = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ROW_AW-1:0] addr;
		logic [ROW_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [ROW_AW-1:0] addr;
	} ram_rd_t;

	// Multiplication modulo 65537, where a zero word stands for 65536.
	function automatic logic [15:0] mulmod(input logic [15:0] a, input logic [15:0] b);
		logic [31:0] p;
		logic [15:0] lo;
		logic [15:0] hi;
		p  = 32'(a) * 32'(b);
		lo = p[15:0];
		hi = p[31:16];
		if (a == 16'd0) begin
			mulmod = 16'd1 - b;
		end else if (b == 16'd0) begin
			mulmod = 16'd1 - a;
		end else begin
			mulmod = lo - hi + 16'(lo < hi);
		end
	endfunction

	// Encryption subkey k: the key rotated left by 25 bits per group of
	// eight, then the word at position k mod 8 from the top.
	function automatic logic [15:0] enc_subkey(input logic [KEY_W-1:0] key,
			input logic [KIDX_W-1:0] k);
		logic [2*KEY_W-1:0] dbl;
		logic [6:0]         amt;
		logic [KEY_W-1:0]   rot;
		logic [KEY_W-1:0]   sh;
		amt = 7'(25 * int'(k >> 3));
		dbl = {key, key} << amt;
		rot = dbl[2*KEY_W-1:KEY_W];
		sh  = rot >> (7'd112 - {k[2:0], 4'b0000});
		enc_subkey = sh[15:0];
	endfunction

endpackage

// ===== hdl/icfb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfb_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module icfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/icfb_keysched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfb_keysched: subkey expansion sequencer
// Builds the encryption and decryption subkey rows one slot at a time and
// writes each finished row to the subkey memory. Inverses modulo 65537 are
// taken as v^65535 by a square-and-multiply loop, one product per cycle.
// ----------------------------------------------------------------------------
module icfb_keysched
	import icfb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output ram_wr_t          wr,
	output logic             busy
);

	typedef enum logic [1:0] {KS_IDLE, KS_SLOT, KS_INV, KS_WRITE} ks_state_t;
	typedef enum logic [1:0] {OP_COPY, OP_NEG, OP_INV, OP_ZERO} ks_op_t;

	ks_state_t         state_q;
	logic [ROW_AW-1:0] row_q;
	logic [2:0]        slot_q;
	logic [ROW_W-1:0]  row_data_q;
	logic [15:0]       acc_q;
	logic [15:0]       inv_v_q;
	logic [3:0]        inv_cnt_q;
	logic              inv_ph_q;

	logic              is_dec;
	logic [ROW_AW-1:0] er;
	logic [KIDX_W-1:0] base;
	logic [KIDX_W-1:0] src;
	ks_op_t            op;
	logic [15:0]       raw;
	logic [15:0]       slot_val;
	logic [15:0]       prod;

	// Map the current row and slot to a source subkey and an operation.
	always_comb begin
		is_dec = (row_q > ROW_AW'(ROUND_COUNT));
		er     = is_dec ? (row_q - ROW_AW'(ROUND_COUNT + 1)) : row_q;
		base   = KIDX_W'(6 * (ROUND_COUNT - int'(er)));
		src    = '0;
		op     = OP_ZERO;
		if (!is_dec) begin
			src = KIDX_W'(6 * int'(er) + int'(slot_q));
			if (er == ROW_AW'(ROUND_COUNT) && slot_q >= 3'd4) begin
				op = OP_ZERO;
			end else begin
				op = OP_COPY;
			end
		end else if (er == ROW_AW'(ROUND_COUNT)) begin
			src = KIDX_W'(slot_q);
			if (slot_q == 3'd0 || slot_q == 3'd3) begin
				op = OP_INV;
			end else if (slot_q < 3'd4) begin
				op = OP_NEG;
			end else begin
				op = OP_ZERO;
			end
		end else begin
			// The first decryption round keeps the additive subkeys in place;
			// every later one swaps them.
			unique case (slot_q)
				3'd0: begin
					src = base;
					op  = OP_INV;
				end
				3'd1: begin
					src = base + ((er == '0) ? KIDX_W'(1) : KIDX_W'(2));
					op  = OP_NEG;
				end
				3'd2: begin
					src = base + ((er == '0) ? KIDX_W'(2) : KIDX_W'(1));
					op  = OP_NEG;
				end
				3'd3: begin
					src = base + KIDX_W'(3);
					op  = OP_INV;
				end
				3'd4: begin
					src = base - KIDX_W'(2);
					op  = OP_COPY;
				end
				3'd5: begin
					src = base - KIDX_W'(1);
					op  = OP_COPY;
				end
				default: begin
					src = '0;
					op  = OP_ZERO;
				end
			endcase
		end
		raw = enc_subkey(key, src);
		unique case (op)
			OP_COPY: slot_val = raw;
			OP_NEG:  slot_val = 16'd0 - raw;
			OP_INV:  slot_val = raw;
			OP_ZERO: slot_val = '0;
			default: slot_val = '0;
		endcase
		prod = inv_ph_q ? mulmod(acc_q, inv_v_q) : mulmod(acc_q, acc_q);
	end

	// Sequencer: slots, inverse iterations and row writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= KS_SLOT;
			row_q      <= '0;
			slot_q     <= '0;
			row_data_q <= '0;
			acc_q      <= '0;
			inv_v_q    <= '0;
			inv_cnt_q  <= '0;
			inv_ph_q   <= 1'b0;
		end else if (start) begin
			state_q <= KS_SLOT;
			row_q   <= '0;
			slot_q  <= '0;
		end else begin
			unique case (state_q)
				KS_IDLE: begin
					state_q <= KS_IDLE;
				end
				KS_SLOT: begin
					if (op == OP_INV) begin
						inv_v_q   <= raw;
						acc_q     <= 16'd1;
						inv_cnt_q <= '0;
						inv_ph_q  <= 1'b0;
						state_q   <= KS_INV;
					end else begin
						for (int j = 0; j < 6; j++) begin
							if (slot_q == 3'(j)) begin
								row_data_q[ROW_W-1-16*j -: 16] <= slot_val;
							end
						end
						slot_q  <= slot_q + 3'd1;
						state_q <= (slot_q == 3'd5) ? KS_WRITE : KS_SLOT;
					end
				end
				KS_INV: begin
					acc_q    <= prod;
					inv_ph_q <= ~inv_ph_q;
					if (inv_ph_q) begin
						inv_cnt_q <= inv_cnt_q + 4'd1;
						if (inv_cnt_q == 4'd15) begin
							for (int j = 0; j < 6; j++) begin
								if (slot_q == 3'(j)) begin
									row_data_q[ROW_W-1-16*j -: 16] <= prod;
								end
							end
							slot_q  <= slot_q + 3'd1;
							state_q <= (slot_q == 3'd5) ? KS_WRITE : KS_SLOT;
						end
					end
				end
				KS_WRITE: begin
					slot_q <= '0;
					if (row_q == ROW_AW'(ROW_COUNT - 1)) begin
						state_q <= KS_IDLE;
					end else begin
						row_q   <= row_q + ROW_AW'(1);
						state_q <= KS_SLOT;
					end
				end
				default: state_q <= KS_IDLE;
			endcase
		end
	end

	assign wr.we   = (state_q == KS_WRITE);
	assign wr.addr = row_q;
	assign wr.data = row_data_q;
	assign busy    = (state_q != KS_IDLE);

endmodule

// ===== hdl/icfb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfb_core: IDEA round engine with ECB and CFB handling
// Runs each round from one subkey row, applies the output
// transform, forms the CFB result and updates the feedback register.
// ----------------------------------------------------------------------------
module icfb_core
	import icfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [63:0]       block_in,
	input  logic [3:0]        byte_count,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [63:0]       block_out,
	input  logic              ks_busy,
	input  logic              cfg_busy,
	input  logic              iv_we,
	input  logic [63:0]       iv_data,
	output ram_rd_t           rd,
	input  logic [ROW_W-1:0]  rd_data
);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_OUT} core_state_t;

	core_state_t       state_q;
	logic [1:0]        mode_q;
	logic [63:0]       data_q;
	logic [3:0]        n_q;
	logic              zero_q;
	logic [ROW_AW-1:0] base_q;
	logic [RND_W-1:0]  round_q;
	logic [1:0]        phase_q;
	logic [15:0]       x1_q, x2_q, x3_q, x4_q, t_q;
	logic [63:0]       feedback_q;
	logic              out_valid_q;
	logic [63:0]       block_out_q;

	logic              accept;
	logic              out_free;
	logic [3:0]        n_clamp;
	logic [63:0]       blk;
	logic [15:0]       k0, k1, k2, k3, k4, k5;
	logic [15:0]       ma_a, ma_b, ma, mb;
	logic [15:0]       x3n;
	logic [63:0]       y;
	logic [6:0]        sh;
	logic [63:0]       mask;
	logic [63:0]       res;
	logic [63:0]       ct;
	logic [63:0]       fb_next;

	// Handshake and subkey slots
	always_comb begin
		in_stall = (state_q != C_IDLE) || ks_busy || cfg_busy;
		accept   = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		n_clamp  = (byte_count > 4'd8) ? 4'd8 : byte_count;
		blk      = (mode[1]) ? feedback_q : block_in;
		k0 = rd_data[ROW_W-1  -: 16];
		k1 = rd_data[ROW_W-17 -: 16];
		k2 = rd_data[ROW_W-33 -: 16];
		k3 = rd_data[ROW_W-49 -: 16];
		k4 = rd_data[ROW_W-65 -: 16];
		k5 = rd_data[ROW_W-81 -: 16];
	end

	// Subkey row reads: the first row at acceptance, the next one in the
	// last cycle of each round.
	always_comb begin
		rd.re   = accept || (state_q == C_RUN && phase_q == 2'd2);
		if (accept) begin
			rd.addr = (mode == MODE_ECB_DEC) ? ROW_AW'(ROUND_COUNT + 1) : '0;
		end else begin
			rd.addr = base_q + ROW_AW'(round_q) + ROW_AW'(1);
		end
	end

	// Shared multipliers and round arithmetic
	always_comb begin
		if (state_q == C_OUT || phase_q == 2'd0) begin
			ma_a = x1_q;
			ma_b = k0;
		end else if (phase_q == 2'd1) begin
			ma_a = x3_q ^ x1_q;
			ma_b = k4;
		end else begin
			ma_a = (x2_q ^ x4_q) + t_q;
			ma_b = k5;
		end
		ma  = mulmod(ma_a, ma_b);
		mb  = mulmod(x4_q, k3);
		x3n = t_q + ma;
		y   = {ma, x3_q + k1, x2_q + k2, mb};
	end

	// Result forming for ECB and CFB
	always_comb begin
		sh   = {n_q, 3'b000};
		mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> sh);
		if (mode_q[1] == 1'b0) begin
			res = y;
			ct  = y;
		end else begin
			res = (data_q ^ y) & mask;
			ct  = (mode_q == MODE_CFB_ENC) ? res : (data_q & mask);
		end
		fb_next = (feedback_q << sh) | (ct >> (7'd64 - sh));
		if (zero_q) begin
			res = '0;
		end
	end

	// Control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			mode_q      <= MODE_ECB_ENC;
			data_q      <= '0;
			n_q         <= '0;
			zero_q      <= 1'b0;
			base_q      <= '0;
			round_q     <= '0;
			phase_q     <= '0;
			x1_q        <= '0;
			x2_q        <= '0;
			x3_q        <= '0;
			x4_q        <= '0;
			t_q         <= '0;
			feedback_q  <= '0;
			out_valid_q <= 1'b0;
			block_out_q <= '0;
		end else begin
			// The output transform refills the register itself when it frees.
			if (out_valid_q && !out_stall && state_q != C_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (iv_we) begin
				feedback_q <= iv_data;
			end
			unique case (state_q)
				C_IDLE: begin
					if (accept) begin
						mode_q  <= mode;
						data_q  <= block_in;
						n_q     <= mode[1] ? n_clamp : 4'd8;
						zero_q  <= mode[1] && (n_clamp == 4'd0);
						base_q  <= (mode == MODE_ECB_DEC) ? ROW_AW'(ROUND_COUNT + 1) : '0;
						round_q <= '0;
						phase_q <= '0;
						{x1_q, x2_q, x3_q, x4_q} <= blk;
						state_q <= (mode[1] && n_clamp == 4'd0) ? C_OUT : C_RUN;
					end
				end
				C_RUN: begin
					unique case (phase_q)
						2'd0: begin
							x1_q    <= ma;
							x2_q    <= x2_q + k1;
							x3_q    <= x3_q + k2;
							x4_q    <= mb;
							phase_q <= 2'd1;
						end
						2'd1: begin
							t_q     <= ma;
							phase_q <= 2'd2;
						end
						2'd2: begin
							x1_q    <= x1_q ^ ma;
							x4_q    <= x4_q ^ x3n;
							x2_q    <= ma ^ x3_q;
							x3_q    <= x3n ^ x2_q;
							phase_q <= 2'd0;
							if (round_q == RND_W'(ROUND_COUNT - 1)) begin
								state_q <= C_OUT;
							end else begin
								round_q <= round_q + RND_W'(1);
							end
						end
						default: phase_q <= 2'd0;
					endcase
				end
				C_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						block_out_q <= res;
						if (mode_q[1] && !zero_q && !iv_we) begin
							feedback_q <= fb_next;
						end
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign block_out = block_out_q;

	// A new word is only taken with the engine free.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == C_IDLE && !ks_busy))
		else $error("word accepted while engine busy");

	// The round phase counter never reaches its unused code.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("round phase out of range");

	// Results appear only after the output transform state.
	a_out_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == C_OUT)
		else $error("result raised outside the output transform");

	// The round counter stays within the round count.
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_q < RND_W'(ROUND_COUNT))
		else $error("round counter out of range");

endmodule

// ===== hdl/idea_block_cipher_cfb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idea_block_cipher_cfb: IDEA block cipher, ECB and CFB modes
// Subkeys live in one memory, one row per round or output transform and
// direction; a sequencer refills it after reset and after every key write.
//
//   Port group | Direction | Handshake          | Carries
//   in         | input     | in_valid/in_stall  | mode, block_in, byte_count
//   out        | output    | out_valid/out_stall| block_out
//   cfg        | input     | cfg_we             | cfg_index, cfg_data
//
// Each word runs every round through the two shared multipliers, then the
// output transform; a new word is accepted once the result is registered and
// no subkey rebuild or configuration write is under way.
// After reset and after each key write the subkey memory is rebuilt before
// words are accepted: 2*(ROUND_COUNT+1) rows, each built slot by slot and
// then written, with 2*(ROUND_COUNT+1) inverses among the decryption subkeys.
// A stalled result holds in the output register while the next word runs.
// ----------------------------------------------------------------------------
module idea_block_cipher_cfb
	import icfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] block_in,
	input  logic [3:0]  byte_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]      key_high_q;
	logic [63:0]      key_low_q;
	logic             key_we;
	logic             iv_we;
	logic             ks_busy;
	ram_wr_t          wr;
	ram_rd_t          rd;
	logic [ROW_W-1:0] rd_data;

	// Configuration decode
	always_comb begin
		key_we = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);
		iv_we  = cfg_we && (cfg_index == CFG_IV);
	end

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end
			if (cfg_index == CFG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end
		end
	end

	icfb_keysched u_keysched (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (key_we),
		.key    ({key_high_q, key_low_q}),
		.wr     (wr),
		.busy   (ks_busy)
	);

	icfb_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROW_COUNT)
	) u_subkey_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (rd_data)
	);

	icfb_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.block_in   (block_in),
		.byte_count (byte_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.block_out  (block_out),
		.ks_busy    (ks_busy),
		.cfg_busy   (cfg_we),
		.iv_we      (iv_we),
		.iv_data    (cfg_data),
		.rd         (rd),
		.rd_data    (rd_data)
	);

endmodule
